// File: rtl/raae_pkg.sv
// Package for the register allocator with age-based eviction.
// Holds sizes, codes and the structs passed between the control unit and the cells.
// No dependencies.
package raae_pkg;

    localparam int HOST_REGS   = 16;
    localparam int SPILL_SLOTS = 32;

    localparam int HIDX_W = (HOST_REGS > 1) ? $clog2(HOST_REGS) : 1;
    localparam int CNT_W  = $clog2(HOST_REGS + 1);
    localparam int SP_W   = (SPILL_SLOTS > 1) ? $clog2(SPILL_SLOTS) : 1;
    localparam int AGE_W  = 8;

    localparam logic [5:0]       VREG_INVALID = 6'd63;
    localparam logic [AGE_W-1:0] AGE_MAX      = 8'd255;

    localparam logic [1:0] K_LOOKUP = 2'd0;
    localparam logic [1:0] K_AGE    = 2'd1;
    localparam logic [1:0] K_PIN    = 2'd2;
    localparam logic [1:0] K_UNPIN  = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ALL_PINNED = 3'd1;
    localparam logic [2:0] ST_INVALID    = 3'd2;
    localparam logic [2:0] ST_PIN_BUSY   = 3'd3;
    localparam logic [2:0] ST_UNTRACKED  = 3'd4;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] vreg;
        logic       is_write;
        logic [3:0] pin_host;
        logic [5:0] src1_vreg;
        logic       src1_is_reg;
        logic [5:0] src2_vreg;
        logic       src2_is_reg;
        logic [5:0] dest_vreg;
        logic       dest_is_reg;
    } t_item;

    typedef struct packed {
        logic [3:0] host_reg;
        logic       host_valid;
        logic       spill_store;
        logic [5:0] evicted_vreg;
        logic       restore;
        logic [2:0] status;
    } t_res;

    // search query seen by every cell during a sweep
    typedef struct packed {
        logic [5:0] vreg;
        logic [3:0] pin_host;
    } t_qry;

    // search word handed from cell to cell
    typedef struct packed {
        logic              hit_f;
        logic [HIDX_W-1:0] hit_idx;
        logic              emp_f;
        logic [HIDX_W-1:0] emp_idx;
        logic              best_f;
        logic [AGE_W-1:0]  best_age;
        logic [HIDX_W-1:0] best_idx;
        logic [5:0]        best_vreg;
        logic              pin_busy;
    } t_tok;

    // update broadcast to all cells at the end of a sweep
    typedef struct packed {
        logic              age_upd;
        logic [5:0]        src1_vreg;
        logic              src1_is_reg;
        logic [5:0]        src2_vreg;
        logic              src2_is_reg;
        logic [5:0]        dest_vreg;
        logic              dest_is_reg;
        logic              wr_en;
        logic [HIDX_W-1:0] idx;
        logic [5:0]        wr_vreg;
        logic              set_pin;
        logic              clr_pin;
        logic              clr_age;
    } t_cmd;

    function automatic logic tracked(input logic [5:0] v);
        return int'(v) < SPILL_SLOTS;
    endfunction

endpackage

// File: rtl/raae_cell.sv
// One host register entry of the allocator chain: mapping, age and pin bit.
// Merges its entry into the search word and passes it on each cycle.
// Depends on raae_pkg.
module raae_cell
    import raae_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [HIDX_W-1:0] i_idx,
    input  t_qry              i_qry,
    input  t_cmd              i_cmd,
    input  t_tok              i_tok,
    output t_tok              o_tok
);

    logic             r_empty;
    logic [5:0]       r_vreg;
    logic [AGE_W-1:0] r_age;
    logic             r_pinned;

    logic my_hit;
    logic op_hit;
    logic sel;
    t_tok n_tok;

    assign my_hit = !r_empty && (r_vreg == i_qry.vreg);
    assign op_hit = !r_empty &&
                    ((i_cmd.src1_is_reg && r_vreg == i_cmd.src1_vreg) ||
                     (i_cmd.src2_is_reg && r_vreg == i_cmd.src2_vreg) ||
                     (i_cmd.dest_is_reg && r_vreg == i_cmd.dest_vreg));
    assign sel    = (i_cmd.idx == i_idx);

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit_f && my_hit) begin
            n_tok.hit_f   = 1'b1;
            n_tok.hit_idx = i_idx;
        end
        if (!i_tok.emp_f && r_empty) begin
            n_tok.emp_f   = 1'b1;
            n_tok.emp_idx = i_idx;
        end
        if (!r_pinned && (!i_tok.best_f || r_age > i_tok.best_age)) begin
            n_tok.best_f    = 1'b1;
            n_tok.best_age  = r_age;
            n_tok.best_idx  = i_idx;
            n_tok.best_vreg = r_vreg;
        end
        if (!r_empty && i_qry.pin_host[HIDX_W-1:0] == i_idx) begin
            n_tok.pin_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        o_tok <= n_tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty  <= 1'b1;
            r_age    <= '0;
            r_pinned <= 1'b0;
        end else begin
            if (i_cmd.age_upd) begin
                if (op_hit) begin
                    r_age <= '0;
                end else if (r_age != AGE_MAX) begin
                    r_age <= r_age + 1'b1;
                end
            end
            if (sel && i_cmd.clr_age) begin
                r_age <= '0;
            end
            if (sel && i_cmd.wr_en) begin
                r_empty <= 1'b0;
            end
            if (sel && i_cmd.set_pin) begin
                r_pinned <= 1'b1;
            end
            if (sel && i_cmd.clr_pin) begin
                r_pinned <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel && i_cmd.wr_en) begin
            r_vreg <= i_cmd.wr_vreg;
        end
    end

endmodule

// File: rtl/raae_ctrl.sv
// Control unit of the allocator: handshakes, sweep counter, spilled-vreg mask,
// decision from the final search word and the output register.
// Depends on raae_pkg.
module raae_ctrl
    import raae_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_item i_item,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_res  o_res,
    output t_qry  o_qry,
    output t_cmd  o_cmd,
    input  t_tok  i_tok
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_SWEEP = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [SPILL_SLOTS-1:0] r_spilled, n_spilled;
    logic                   r_ovalid, n_ovalid;
    t_item                  r_item;
    t_res                   r_res;

    t_res res;
    t_cmd cmd;
    logic done;
    logic fire;
    logic placed;
    logic [SPILL_SLOTS-1:0] set_m, clr_m;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_res       = r_res;
    assign o_qry       = '{vreg: r_item.vreg, pin_host: r_item.pin_host};
    assign o_cmd       = cmd;

    assign done = (r_state == S_SWEEP) && (r_cnt == CNT_W'(HOST_REGS));
    assign fire = done && (!r_ovalid || i_out_ready);

    always_comb begin
        res    = '0;
        cmd    = '0;
        placed = 1'b0;
        set_m  = '0;
        clr_m  = '0;
        cmd.src1_vreg   = r_item.src1_vreg;
        cmd.src1_is_reg = r_item.src1_is_reg;
        cmd.src2_vreg   = r_item.src2_vreg;
        cmd.src2_is_reg = r_item.src2_is_reg;
        cmd.dest_vreg   = r_item.dest_vreg;
        cmd.dest_is_reg = r_item.dest_is_reg;
        cmd.wr_vreg     = r_item.vreg;
        case (r_item.kind)
            K_AGE: begin
                cmd.age_upd = 1'b1;
            end
            K_PIN: begin
                if (r_item.vreg == VREG_INVALID) begin
                    res.status = ST_INVALID;
                end else if (32'(r_item.pin_host) >= HOST_REGS || i_tok.pin_busy) begin
                    res.status = ST_PIN_BUSY;
                end else begin
                    cmd.wr_en      = 1'b1;
                    cmd.set_pin    = 1'b1;
                    cmd.idx        = r_item.pin_host[HIDX_W-1:0];
                    res.host_reg   = r_item.pin_host;
                    res.host_valid = 1'b1;
                end
            end
            K_UNPIN: begin
                if (r_item.vreg == VREG_INVALID) begin
                    res.status = ST_INVALID;
                end else if (i_tok.hit_f) begin
                    cmd.clr_pin    = 1'b1;
                    cmd.idx        = i_tok.hit_idx;
                    res.host_reg   = 4'(i_tok.hit_idx);
                    res.host_valid = 1'b1;
                end
            end
            K_LOOKUP: begin
                if (r_item.vreg == VREG_INVALID) begin
                    res.status = ST_INVALID;
                end else if (i_tok.hit_f) begin
                    res.host_reg   = 4'(i_tok.hit_idx);
                    res.host_valid = 1'b1;
                    cmd.idx        = i_tok.hit_idx;
                end else if (i_tok.emp_f) begin
                    placed         = 1'b1;
                    cmd.wr_en      = 1'b1;
                    cmd.idx        = i_tok.emp_idx;
                    res.host_reg   = 4'(i_tok.emp_idx);
                    res.host_valid = 1'b1;
                end else if (i_tok.best_f) begin
                    placed           = 1'b1;
                    cmd.wr_en        = 1'b1;
                    cmd.idx          = i_tok.best_idx;
                    res.host_reg     = 4'(i_tok.best_idx);
                    res.host_valid   = 1'b1;
                    res.spill_store  = 1'b1;
                    res.evicted_vreg = i_tok.best_vreg;
                    if (tracked(i_tok.best_vreg)) begin
                        set_m[i_tok.best_vreg[SP_W-1:0]] = 1'b1;
                    end else begin
                        res.status = ST_UNTRACKED;
                    end
                end else begin
                    res.status = ST_ALL_PINNED;
                end
                if (placed && !r_item.is_write) begin
                    if (!tracked(r_item.vreg)) begin
                        res.status = ST_UNTRACKED;
                    end else if (r_spilled[r_item.vreg[SP_W-1:0]]) begin
                        res.restore = 1'b1;
                        cmd.clr_age = 1'b1;
                        clr_m[r_item.vreg[SP_W-1:0]] = 1'b1;
                    end
                end
            end
            default: begin
                res = '0;
            end
        endcase
        if (!fire) begin
            cmd   = '0;
            set_m = '0;
            clr_m = '0;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_spilled = (r_spilled | set_m) & ~clr_m;
        n_ovalid  = r_ovalid;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SWEEP;
                    n_cnt   = '0;
                end
            end
            S_SWEEP: begin
                if (!done) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (fire) begin
                    n_state  = S_IDLE;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_spilled <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_spilled <= n_spilled;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_item;
        end
        if (fire) begin
            r_res <= res;
        end
    end

endmodule

// File: rtl/register_allocator_age_evict_top.sv
// Register allocator with age-based eviction, top level.
// Takes one request word, returns one result word: host register, spill and restore.
// Depends on raae_pkg, raae_cell and raae_ctrl.
//
// Input stream: s_axis_tuser carries the request kind (lookup, age update, pin,
// unpin); s_axis_tdata carries the virtual register, write flag, pin target and
// the three operands of a finished instruction.
// Output stream: m_axis_tdata carries host register, valid flag, spill flag,
// evicted register, restore flag and status.
// Each request is searched by a row of HOST_REGS entry cells; the search word
// moves one cell per cycle, and the result word is loaded into the output register
// once the word has passed the last cell; one request is in flight at a time, so
// the block takes no new request before it has finished the last one.
// The block is ready for the next request once the result is loaded into the output
// register, even while that result waits.
// A stalled receiver holds the result; a finished search then waits for the
// output register to drain before updating the entries.
// Reset empties all entries, clears ages, pins and spilled marks; the block is
// ready for requests as soon as reset is released.
module register_allocator_age_evict_top
    import raae_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] vreg, [6] is_write, [10:7] pin_host, [16:11] src1_vreg,
    // [17] src1_is_reg, [23:18] src2_vreg, [24] src2_is_reg,
    // [30:25] dest_vreg, [31] dest_is_reg
    input  logic [31:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] host_reg, [4] host_valid, [5] spill_store, [11:6] evicted_vreg,
    // [12] restore, [15:13] status
    output logic [15:0] m_axis_tdata
);

    t_item item;
    t_res  res;
    t_qry  qry;
    t_cmd  cmd;
    t_tok  tok [HOST_REGS+1];

    assign item.kind        = s_axis_tuser;
    assign item.vreg        = s_axis_tdata[5:0];
    assign item.is_write    = s_axis_tdata[6];
    assign item.pin_host    = s_axis_tdata[10:7];
    assign item.src1_vreg   = s_axis_tdata[16:11];
    assign item.src1_is_reg = s_axis_tdata[17];
    assign item.src2_vreg   = s_axis_tdata[23:18];
    assign item.src2_is_reg = s_axis_tdata[24];
    assign item.dest_vreg   = s_axis_tdata[30:25];
    assign item.dest_is_reg = s_axis_tdata[31];

    assign m_axis_tdata = {res.status, res.restore, res.evicted_vreg,
                           res.spill_store, res.host_valid, res.host_reg};

    assign tok[0] = '0;

    raae_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_item      (item),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_res       (res),
        .o_qry       (qry),
        .o_cmd       (cmd),
        .i_tok       (tok[HOST_REGS])
    );

    for (genvar k = 0; k < HOST_REGS; k++) begin : g_cell
        raae_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (HIDX_W'(k)),
            .i_qry   (qry),
            .i_cmd   (cmd),
            .i_tok   (tok[k]),
            .o_tok   (tok[k+1])
        );
    end

endmodule

// File: rtl/raae_checker.sv
// Port-level checks for the register allocator top level.
// Bound to register_allocator_age_evict_top; depends on no package.
module raae_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while one is in flight");

    a_no_host_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[3:0] == 4'd0 &&
        !m_axis_tdata[5] && !m_axis_tdata[12])
        else $error("host fields set without a valid assignment");

    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[5] |-> m_axis_tdata[11:6] == 6'd0)
        else $error("evicted register reported without a spill");

    a_invalid_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[15:13] == 3'd2 || m_axis_tdata[15:13] == 3'd1 ||
        m_axis_tdata[15:13] == 3'd3) |-> !m_axis_tdata[4])
        else $error("failed request reports a host register");

endmodule

bind register_allocator_age_evict_top raae_checker u_raae_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
